// File: hdl/sfmp_pkg.sv
// types, constants and character codes shared by the mode parser
package sfmp_pkg;

	localparam int unsigned MODE_W = 12;

	localparam logic [MODE_W-1:0] M_USER   = 12'o5700;
	localparam logic [MODE_W-1:0] M_GROUP  = 12'o2070;
	localparam logic [MODE_W-1:0] M_OTHER  = 12'o0007;
	localparam logic [MODE_W-1:0] M_ALL    = 12'o1777;
	localparam logic [MODE_W-1:0] M_READ   = 12'o0444;
	localparam logic [MODE_W-1:0] M_WRITE  = 12'o0222;
	localparam logic [MODE_W-1:0] M_EXEC   = 12'o0111;
	localparam logic [MODE_W-1:0] M_SETID  = 12'o6000;
	localparam logic [MODE_W-1:0] M_STICKY = 12'o1000;
	localparam logic [MODE_W-1:0] M_RWX    = 12'o0777;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_PLUS  = 8'h2b;
	localparam logic [7:0] CH_COMMA = 8'h2c;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_7     = 8'h37;
	localparam logic [7:0] CH_EQ    = 8'h3d;
	localparam logic [7:0] CH_A     = 8'h61;
	localparam logic [7:0] CH_G     = 8'h67;
	localparam logic [7:0] CH_O     = 8'h6f;
	localparam logic [7:0] CH_R     = 8'h72;
	localparam logic [7:0] CH_S     = 8'h73;
	localparam logic [7:0] CH_T     = 8'h74;
	localparam logic [7:0] CH_U     = 8'h75;
	localparam logic [7:0] CH_W     = 8'h77;
	localparam logic [7:0] CH_X     = 8'h78;

	typedef enum logic [6:0] {
		PH_START      = 7'b0000001,
		PH_OCTAL      = 7'b0000010,
		PH_WHO        = 7'b0000100,
		PH_PERM_FIRST = 7'b0001000,
		PH_PERM       = 7'b0010000,
		PH_COPIED     = 7'b0100000,
		PH_ERROR      = 7'b1000000
	} phase_t;

	typedef enum logic [1:0] {
		OP_NONE = 2'd0,
		OP_ADD  = 2'd1,
		OP_SUB  = 2'd2,
		OP_SET  = 2'd3
	} op_t;

	typedef struct packed {
		phase_t             phase;
		logic [MODE_W-1:0]  running;
		logic [MODE_W-1:0]  who;
		op_t                op;
		logic [MODE_W-1:0]  perm;
		logic [MODE_W-1:0]  octal;
	} parse_state_t;

	localparam parse_state_t STATE_CLEAR = '{
		phase:   PH_START,
		running: '0,
		who:     '0,
		op:      OP_NONE,
		perm:    '0,
		octal:   '0
	};

	typedef struct packed {
		logic               emit;
		logic [MODE_W-1:0]  mode;
		logic               bad;
	} parse_result_t;

endpackage

// File: hdl/symbolic_file_mode_parser.sv
// symbolic file mode parser: input register, parse step, result register
// flow: an accepted character waits in the input register until the parse step takes it;
//   a result goes to the result register when its terminating zero is parsed
// throughput: one character per cycle, stalled only while a finished result waits
//   on a stalled output and the character in the input register also ends a string
// reset: arst_n clears the parse state, the umask register and both valid flags
module symbolic_file_mode_parser
	import sfmp_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               umask_we,
	input  logic [MODE_W-1:0]  umask_wdata,
	input  logic               req_valid,
	output logic               req_stall,
	input  logic [7:0]         ch,
	input  logic [MODE_W-1:0]  start_mode,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output logic [MODE_W-1:0]  mode,
	output logic               invalid
);

	logic [MODE_W-1:0]  umask_bits_q;
	logic               valid_s1;
	logic [7:0]         ch_s1;
	logic [MODE_W-1:0]  start_mode_s1;
	parse_state_t       st_q;
	parse_state_t       st_next;
	parse_result_t      res;
	logic               out_free;
	logic               adv;
	logic               accept;
	logic               rsp_valid_q;
	logic [MODE_W-1:0]  mode_q;
	logic               invalid_q;

	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign adv       = valid_s1 && (!res.emit || out_free);
	assign req_stall = valid_s1 && !adv;
	assign accept    = req_valid && !req_stall;

	sfmp_step u_step (
		.st         (st_q),
		.ch         (ch_s1),
		.start_mode (start_mode_s1),
		.umask_bits (umask_bits_q),
		.st_next    (st_next),
		.res        (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			umask_bits_q <= '0;
		end else if (umask_we) begin
			umask_bits_q <= umask_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ch_s1         <= ch;
			start_mode_s1 <= start_mode;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= STATE_CLEAR;
		end else if (adv) begin
			st_q <= st_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (adv && res.emit) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res.emit) begin
			mode_q    <= res.mode;
			invalid_q <= res.bad;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign mode      = mode_q;
	assign invalid   = invalid_q;

endmodule

// File: hdl/sfmp_step.sv
// next-state and result logic for one character of the mode string
module sfmp_step
	import sfmp_pkg::*;
(
	input  parse_state_t       st,
	input  logic [7:0]         ch,
	input  logic [MODE_W-1:0]  start_mode,
	input  logic [MODE_W-1:0]  umask_bits,
	output parse_state_t       st_next,
	output parse_result_t      res
);

	parse_state_t       s;
	logic               do_who;
	logic               do_perm;
	logic               do_apply;
	logic               do_after;
	logic [MODE_W-1:0]  cls;
	logic [MODE_W-1:0]  cls9;
	logic [MODE_W-1:0]  apply_b;

	// class copy from the running mode as it stands before this character
	always_comb begin
		case (ch)
			CH_U:    cls = (st.running & M_USER) >> 6;
			CH_G:    cls = (st.running & M_GROUP) >> 3;
			default: cls = st.running & M_OTHER;
		endcase
		cls9 = cls & M_RWX;
	end

	always_comb begin
		s        = st;
		res      = '{emit: 1'b0, mode: '0, bad: 1'b0};
		do_who   = 1'b0;
		do_perm  = 1'b0;
		do_apply = 1'b0;
		do_after = 1'b0;
		apply_b  = '0;

		// first character of a string samples the file's mode
		if (s.phase == PH_START) begin
			s.running = start_mode;
			s.octal   = '0;
			s.phase   = PH_OCTAL;
		end

		case (s.phase)
			PH_OCTAL: begin
				if (ch inside {[CH_0:CH_7]}) begin
					s.octal = (s.octal << 3) + {9'd0, ch[2:0]};
				end else if (ch == CH_NUL) begin
					res = '{emit: 1'b1, mode: s.octal, bad: 1'b0};
				end else begin
					s.who  = '0;
					s.phase = PH_WHO;
					do_who = 1'b1;
				end
			end
			PH_WHO: begin
				do_who = 1'b1;
			end
			PH_PERM_FIRST: begin
				if (ch inside {CH_U, CH_G, CH_O}) begin
					s.perm  = cls9 | (cls9 << 3) | (cls9 << 6);
					s.phase = PH_COPIED;
				end else begin
					do_perm = 1'b1;
				end
			end
			PH_PERM: begin
				do_perm = 1'b1;
			end
			PH_COPIED: begin
				do_apply = 1'b1;
				do_after = 1'b1;
			end
			default: begin
				// error phase: swallow until the terminating zero
				if (ch == CH_NUL) begin
					res = '{emit: 1'b1, mode: '0, bad: 1'b1};
				end else begin
					s.phase = PH_ERROR;
				end
			end
		endcase

		if (do_who) begin
			case (ch)
				CH_U: s.who = s.who | M_USER;
				CH_G: s.who = s.who | M_GROUP;
				CH_O: s.who = s.who | M_OTHER;
				CH_A: s.who = s.who | M_ALL;
				default: begin
					if (s.who == '0) begin
						s.who = M_ALL & ~umask_bits;
					end
					do_after = 1'b1;
				end
			endcase
		end

		if (do_perm) begin
			s.phase = PH_PERM;
			case (ch)
				CH_R: s.perm = s.perm | M_READ;
				CH_W: s.perm = s.perm | M_WRITE;
				CH_X: s.perm = s.perm | M_EXEC;
				CH_S: s.perm = s.perm | M_SETID;
				CH_T: s.perm = s.perm | M_STICKY;
				default: begin
					do_apply = 1'b1;
					do_after = 1'b1;
				end
			endcase
		end

		if (do_apply) begin
			apply_b = s.perm & s.who;
			case (s.op)
				OP_ADD:  s.running = s.running | apply_b;
				OP_SUB:  s.running = s.running & ~apply_b;
				OP_SET:  s.running = (s.running & ~s.who) | apply_b;
				default: s.running = s.running;
			endcase
		end

		if (do_after) begin
			case (ch)
				CH_PLUS: begin
					s.op    = OP_ADD;
					s.perm  = '0;
					s.phase = PH_PERM_FIRST;
				end
				CH_MINUS: begin
					s.op    = OP_SUB;
					s.perm  = '0;
					s.phase = PH_PERM_FIRST;
				end
				CH_EQ: begin
					s.op    = OP_SET;
					s.perm  = '0;
					s.phase = PH_PERM_FIRST;
				end
				CH_COMMA: begin
					s.who   = '0;
					s.phase = PH_WHO;
				end
				CH_NUL: begin
					res = '{emit: 1'b1, mode: s.running, bad: 1'b0};
				end
				default: s.phase = PH_ERROR;
			endcase
		end

		st_next = res.emit ? STATE_CLEAR : s;
	end

endmodule

// File: hdl/sfmp_checker.sv
// port-level checks for the mode parser and their bind
module sfmp_checker
	import sfmp_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               umask_we,
	input  logic [MODE_W-1:0]  umask_wdata,
	input  logic               req_valid,
	input  logic               req_stall,
	input  logic [7:0]         ch,
	input  logic [MODE_W-1:0]  start_mode,
	input  logic               rsp_valid,
	input  logic               rsp_stall,
	input  logic [MODE_W-1:0]  mode,
	input  logic               invalid
);

	// a held result keeps its payload
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(mode) && $stable(invalid))
		else $error("result changed while stalled");

	// a rejected string always reports mode zero
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && invalid |-> mode == '0)
		else $error("invalid result with nonzero mode");

	// input backpressure only comes from a full, stalled output register
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> rsp_valid && rsp_stall)
		else $error("input stalled while output could drain");

	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |-> !rsp_valid && !req_stall)
		else $error("activity during reset");

endmodule

bind symbolic_file_mode_parser sfmp_checker u_sfmp_checker (.*);
